// ----- rtl/core/y2r_pkg.sv -----
// Package for the YUV to RGB converter: pixel and color types, coefficient sets,
// register map constants and the channel clamp.
// No dependencies.
package y2r_pkg;

    localparam int QShift   = 10;
    localparam int AddrW    = 3;
    localparam int ApbDataW = 32;
    localparam int PixelW   = 24;

    // Register index is paddr[2]; only the standard select register exists.
    localparam logic REG_COLOUR_STD = 1'b0;

    typedef logic signed [11:0] t_coef;

    typedef struct packed {
        t_coef rv;
        t_coef gu;
        t_coef gv;
        t_coef bu;
    } t_coef_set;

    // Packed structs list the highest bits first.
    typedef struct packed {
        logic signed [7:0] chroma_red;
        logic signed [7:0] chroma_blue;
        logic        [7:0] luma;
    } t_yuv;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgb;

    typedef struct packed {
        logic bt709;
    } t_cfg;

    function automatic t_coef_set coef_set(input logic bt709);
        t_coef_set c;
        if (bt709) begin
            c.rv = 12'sd1608;
            c.gu = -12'sd191;
            c.gv = -12'sd478;
            c.bu = 12'sd1900;
        end else begin
            c.rv = 12'sd1437;
            c.gu = -12'sd352;
            c.gv = -12'sd731;
            c.bu = 12'sd1812;
        end
        return c;
    endfunction

    function automatic logic [7:0] clamp8(input logic signed [11:0] v);
        logic [7:0] res;
        if (v < 12'sd0) begin
            res = 8'd0;
        end else if (v > 12'sd255) begin
            res = 8'hFF;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/y2r_regs.sv -----
// APB configuration register of the YUV to RGB converter (standard select).
// Depends on y2r_pkg.
module y2r_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [y2r_pkg::AddrW-1:0]     paddr,
    input  logic [y2r_pkg::ApbDataW-1:0]  pwdata,
    output logic [y2r_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready,
    output y2r_pkg::t_cfg                 o_cfg
);

    logic r_bt709;
    logic n_bt709;
    logic wr_std;

    assign pready = 1'b1;
    assign wr_std = psel && penable && pwrite && (paddr[2] == y2r_pkg::REG_COLOUR_STD);

    always_comb begin
        n_bt709 = r_bt709;
        if (wr_std) begin
            n_bt709 = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt709 <= 1'b0;
        end else begin
            r_bt709 <= n_bt709;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == y2r_pkg::REG_COLOUR_STD) begin
            prdata[0] = r_bt709;
        end
    end

    assign o_cfg.bt709 = r_bt709;

endmodule

// ----- rtl/core/y2r_cvt.sv -----
// Color math of the YUV to RGB converter: Q10 chroma products, floor, sum and clamp.
// Depends on y2r_pkg.
module y2r_cvt (
    input  y2r_pkg::t_yuv i_yuv,
    input  y2r_pkg::t_cfg i_cfg,
    output y2r_pkg::t_rgb o_rgb
);

    y2r_pkg::t_coef_set k;
    logic signed [19:0] p_rv, p_gu, p_gv, p_bu;
    logic signed [9:0]  t_rv, t_gu, t_gv, t_bu;
    logic signed [11:0] y_ext, s_r, s_g, s_b;

    assign k = y2r_pkg::coef_set(i_cfg.bt709);

    assign p_rv = $signed(k.rv) * $signed(i_yuv.chroma_red);
    assign p_gu = $signed(k.gu) * $signed(i_yuv.chroma_blue);
    assign p_gv = $signed(k.gv) * $signed(i_yuv.chroma_red);
    assign p_bu = $signed(k.bu) * $signed(i_yuv.chroma_blue);

    // Dropping the low ten bits of a two's complement product floors it.
    assign t_rv = p_rv[19:y2r_pkg::QShift];
    assign t_gu = p_gu[19:y2r_pkg::QShift];
    assign t_gv = p_gv[19:y2r_pkg::QShift];
    assign t_bu = p_bu[19:y2r_pkg::QShift];

    assign y_ext = $signed({4'b0000, i_yuv.luma});
    assign s_r = y_ext + {{2{t_rv[9]}}, t_rv};
    assign s_g = y_ext + {{2{t_gu[9]}}, t_gu} + {{2{t_gv[9]}}, t_gv};
    assign s_b = y_ext + {{2{t_bu[9]}}, t_bu};

    assign o_rgb.red   = y2r_pkg::clamp8(s_r);
    assign o_rgb.green = y2r_pkg::clamp8(s_g);
    assign o_rgb.blue  = y2r_pkg::clamp8(s_b);

endmodule

// ----- rtl/core/yuv_to_rgb_fixed_point.sv -----
// Channel      | Dir | Payload
// s_axis       | in  | tdata[7:0] luma, [15:8] chroma_blue, [23:16] chroma_red
// m_axis       | out | tdata[7:0] red, [15:8] green, [23:16] blue
// APB          | in  | register 0 at byte 0: bit 0 selects BT.709 (1) or BT.601 (0)
//
// One pixel per clock while m_axis does not stall; a result beat passes the input register
// and then the result register before it shows on m_axis.
// The input register feeds the multiply/clamp logic, which feeds the result register.
// Synchronous active-low reset empties both registers and selects BT.601.
// A stall on m_axis holds the result beat; the input register still fills behind it.
// Depends on y2r_pkg, y2r_regs and y2r_cvt.
module yuv_to_rgb_fixed_point (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [y2r_pkg::PixelW-1:0]    i_s_axis_tdata,  // luma, chroma_blue, chroma_red
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [y2r_pkg::PixelW-1:0]    o_m_axis_tdata,  // red, green, blue
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [y2r_pkg::AddrW-1:0]     paddr,
    input  logic [y2r_pkg::ApbDataW-1:0]  pwdata,
    output logic [y2r_pkg::ApbDataW-1:0]  prdata,
    output logic                          pready
);

    y2r_pkg::t_cfg cfg;
    y2r_pkg::t_yuv r_yuv;
    y2r_pkg::t_rgb rgb;
    y2r_pkg::t_rgb r_rgb;
    logic r_v1, n_v1, r_v2, n_v2;
    logic s_acc, adv;

    y2r_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    y2r_cvt u_cvt (
        .i_yuv (r_yuv),
        .i_cfg (cfg),
        .o_rgb (rgb)
    );

    // The result register frees up when empty or when its beat is taken.
    assign adv             = r_v1 && (!r_v2 || i_m_axis_tready);
    assign o_s_axis_tready = !r_v1 || !r_v2 || i_m_axis_tready;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_v1 = r_v1;
        if (s_acc) begin
            n_v1 = 1'b1;
        end else if (adv) begin
            n_v1 = 1'b0;
        end
        n_v2 = r_v2;
        if (adv) begin
            n_v2 = 1'b1;
        end else if (i_m_axis_tready) begin
            n_v2 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_yuv <= i_s_axis_tdata;
        end
        if (adv) begin
            r_rgb <= rgb;
        end
    end

    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = r_rgb;

endmodule

// ----- rtl/core/y2r_chk.sv -----
// Port-level checker for the YUV to RGB converter, bound to the top level.
// Depends on y2r_pkg and yuv_to_rgb_fixed_point.
module y2r_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_axis_tvalid,
    input logic                          o_s_axis_tready,
    input logic                          o_m_axis_tvalid,
    input logic                          i_m_axis_tready,
    input logic [y2r_pkg::PixelW-1:0]    o_m_axis_tdata,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [y2r_pkg::AddrW-1:0]     paddr,
    input logic [y2r_pkg::ApbDataW-1:0]  pwdata,
    input logic [y2r_pkg::ApbDataW-1:0]  prdata
);

    // A stalled result beat holds its data.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result beat changed under stall");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    // Once a pixel is taken, a result beat follows on offer, its own or an older stalled one.
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |-> ##2 o_m_axis_tvalid)
        else $error("accepted pixel did not reach the output");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty output");

    a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[2] == y2r_pkg::REG_COLOUR_STD)
        |=> (paddr[2] != y2r_pkg::REG_COLOUR_STD) || (prdata[0] == $past(pwdata[0])))
        else $error("standard register readback mismatch");

endmodule

bind yuv_to_rgb_fixed_point y2r_chk u_y2r_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);

// ----- bench/tb_yuv_to_rgb_fixed_point.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for yuv_to_rgb_fixed_point: directed and random pixels under
// both coefficient sets, with an independent RGB predictor and APB register writes.
// Depends on y2r_pkg and the RTL of the converter.
module tb_yuv_to_rgb_fixed_point;
    import y2r_pkg::*;

    localparam logic STD_BT601 = 1'b0;
    localparam logic STD_BT709 = 1'b1;
    localparam logic [AddrW-1:0] STD_SEL_ADDR = {REG_COLOUR_STD, 2'b00};
    // Byte address of register index 1, which does not exist; writes there must be dropped.
    localparam logic [AddrW-1:0] UNMAPPED_ADDR = 3'd4;
    localparam int HOLD_CYCLES = 200;
    localparam int RAND_PHASES = 5;
    localparam int PIXELS_PER_PHASE = 86;
    localparam int NUM_DIR_ROWS = 13;

    typedef struct {
        logic [7:0] luma;
        logic [7:0] cb;
        logic [7:0] cr;
        bit         known;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_dir_row;

    // Hand-worked results are valid for BT.601 only.
    t_dir_row dir_rows [NUM_DIR_ROWS] = '{
        '{8'd0,   8'h00, 8'h00, 1'b1, 8'd0,   8'd0,   8'd0},
        '{8'd255, 8'h00, 8'h00, 1'b1, 8'd255, 8'd255, 8'd255},
        '{8'd128, 8'h00, 8'h00, 1'b1, 8'd128, 8'd128, 8'd128},
        '{8'd0,   8'h80, 8'h80, 1'b1, 8'd0,   8'd135, 8'd0},
        '{8'd255, 8'h7F, 8'h7F, 1'b1, 8'd255, 8'd120, 8'd255},
        '{8'd100, 8'hFF, 8'hFF, 1'b1, 8'd98,  8'd100, 8'd98},
        '{8'd100, 8'h01, 8'h01, 1'b1, 8'd101, 8'd98,  8'd101},
        '{8'd255, 8'h80, 8'h80, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd0,   8'h7F, 8'h7F, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'h55,  8'hAA, 8'h55, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'hAA,  8'h55, 8'hAA, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd16,  8'h80, 8'h7F, 1'b0, 8'd0,   8'd0,   8'd0},
        '{8'd235, 8'h7F, 8'h80, 1'b0, 8'd0,   8'd0,   8'd0}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [PixelW-1:0] i_s_axis_tdata;   // luma, chroma_blue, chroma_red
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [PixelW-1:0] o_m_axis_tdata;   // red, green, blue
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [AddrW-1:0]  paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic              pready;

    t_rgb pending_rgb [$];
    logic cfg_bt709;
    int   mismatch_count;
    bit   tx_bursty;
    bit   rx_bursty;
    bit   hold_req;

    yuv_to_rgb_fixed_point i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    function automatic logic [7:0] sat_u8(input int s);
        logic [7:0] res;
        if (s < 0) begin
            res = 8'd0;
        end else if (s > 255) begin
            res = 8'd255;
        end else begin
            res = s[7:0];
        end
        return res;
    endfunction

    // Each Q10 term is floored on its own; >>> on an int is an arithmetic shift.
    function automatic t_rgb predict_rgb(input t_yuv px, input logic bt709);
        int   k_rv;
        int   k_gu;
        int   k_gv;
        int   k_bu;
        int   y;
        int   u;
        int   v;
        t_rgb res;
        if (bt709 == STD_BT709) begin
            k_rv = 1608; k_gu = -191; k_gv = -478; k_bu = 1900;
        end else begin
            k_rv = 1437; k_gu = -352; k_gv = -731; k_bu = 1812;
        end
        y = int'(px.luma);
        u = int'($signed(px.chroma_blue));
        v = int'($signed(px.chroma_red));
        res.red   = sat_u8(y + ((k_rv * v) >>> 10));
        res.green = sat_u8(y + ((k_gu * u) >>> 10) + ((k_gv * v) >>> 10));
        res.blue  = sat_u8(y + ((k_bu * u) >>> 10));
        return res;
    endfunction

    task automatic push_pixel(input t_yuv px, input t_rgb rgb);
        int gap;
        if (tx_bursty && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_rgb.push_back(rgb);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic [AddrW-1:0] addr, input logic [ApbDataW-1:0] data,
                              input logic wr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr && addr == STD_SEL_ADDR) begin
            cfg_bt709 = data[0];
        end
        if (!wr && prdata[0] !== cfg_bt709) begin
            $display("%0t: register read mismatch: expected %0d, actual %0d",
                     $time, cfg_bt709, prdata[0]);
            mismatch_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Output side: checks every beat and drives tready with random stalls and one long hold.
    initial begin
        int   stall_left;
        int   hold_left;
        logic rdy;
        t_rgb got;
        t_rgb want;
        stall_left = 0;
        hold_left  = 0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                got = o_m_axis_tdata;
                if (pending_rgb.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual %h", $time, got);
                    mismatch_count++;
                end else begin
                    want = pending_rgb.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red mismatch: expected %0d, actual %0d",
                                 $time, want.red, got.red);
                        mismatch_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green mismatch: expected %0d, actual %0d",
                                 $time, want.green, got.green);
                        mismatch_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue mismatch: expected %0d, actual %0d",
                                 $time, want.blue, got.blue);
                        mismatch_count++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (rx_bursty && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 18);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            i_m_axis_tready <= rdy;
        end
    end

    initial begin
        t_yuv       px;
        t_rgb       rgb;
        logic       std_sel;
        logic [7:0] corner [4];
        mismatch_count = 0;
        cfg_bt709 = STD_BT601;
        tx_bursty = 1'b1;
        rx_bursty = 1'b1;
        hold_req  = 1'b0;
        corner = '{8'h80, 8'h7F, 8'h00, 8'hFF};
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The first read checks the reset value of the standard select.
        apb_access(STD_SEL_ADDR, '0, 1'b0);
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1) begin
                drain();
                // Upper data bits must be ignored; only bit 0 selects BT.709.
                apb_access(STD_SEL_ADDR, 32'hFFFF_FFFF, 1'b1);
                apb_access(UNMAPPED_ADDR, 32'h0000_0000, 1'b1);
                apb_access(STD_SEL_ADDR, '0, 1'b0);
            end
            foreach (dir_rows[r]) begin
                px.luma        = dir_rows[r].luma;
                px.chroma_blue = dir_rows[r].cb;
                px.chroma_red  = dir_rows[r].cr;
                if (pass == 0 && dir_rows[r].known) begin
                    rgb.red   = dir_rows[r].red;
                    rgb.green = dir_rows[r].green;
                    rgb.blue  = dir_rows[r].blue;
                end else begin
                    rgb = predict_rgb(px, cfg_bt709);
                end
                push_pixel(px, rgb);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            if (ph == 0) begin
                std_sel = STD_BT601;
            end else if (ph == 1) begin
                std_sel = STD_BT709;
            end else begin
                std_sel = 1'($urandom_range(0, 1));
            end
            apb_access(STD_SEL_ADDR, ($urandom() & 32'hFFFF_FFFE) | std_sel, 1'b1);
            apb_access(UNMAPPED_ADDR, $urandom(), 1'b1);
            apb_access(STD_SEL_ADDR, '0, 1'b0);
            // Phase 1 keeps the input busy while the output holds off, so the pipe backs up.
            tx_bursty = (ph != 1) && (ph != RAND_PHASES - 1);
            rx_bursty = (ph != RAND_PHASES - 1);
            if (ph == 1) begin
                hold_req = 1'b1;
            end
            for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
                if (ph == 2 && i == PIXELS_PER_PHASE / 2) begin
                    drain();
                end
                px = PixelW'($urandom());
                if ($urandom_range(0, 7) == 0) begin
                    px.luma        = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    px.chroma_blue = corner[$urandom_range(0, 3)];
                    px.chroma_red  = corner[$urandom_range(0, 3)];
                end
                push_pixel(px, predict_rgb(px, cfg_bt709));
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- yuv_to_rgb_fixed_point.f -----
rtl/core/y2r_pkg.sv
rtl/core/y2r_regs.sv
rtl/core/y2r_cvt.sv
rtl/core/yuv_to_rgb_fixed_point.sv
rtl/core/y2r_chk.sv
bench/tb_yuv_to_rgb_fixed_point.sv
